// ===== sv/tmss_pkg.sv =====
// tmss_pkg: shared types, sizes and codes of the three min-tracking stacks
// no dependencies; used by the channel interfaces, the top level and the check package

package tmss_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int NUM_STACKS  = 3;
  localparam int STORE_DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int KIND_W = 2;
  localparam int SEL_W  = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  typedef enum logic [KIND_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADSTACK = 2'd3
  } status_t;

  // one stored entry: the pushed value and the stack minimum up to it
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] minimum;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/tmss_req_if.sv =====
// tmss_req_if: request channel (valid/ready plus request payload)
// depends on tmss_pkg for field widths

interface tmss_req_if import tmss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        req_type;
  logic [SEL_W-1:0]         stack_sel;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output stack_sel, output push_value,
                  input ready);
  modport sink   (input valid, input req_type, input stack_sel, input push_value,
                  output ready);
endinterface

// ===== sv/tmss_rsp_if.sv =====
// tmss_rsp_if: result channel (valid/ready plus result payload)
// depends on tmss_pkg for field widths

interface tmss_rsp_if import tmss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] top_minimum;
  logic [FILL_W-1:0]        fill_count;

  modport source (output valid, output status, output top_value, output top_minimum,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input top_value, input top_minimum,
                  input fill_count, output ready);
endinterface

// ===== sv/tmss_ram.sv =====
// tmss_ram: generic single-write, single-read ram with registered read data
// no package dependency

module tmss_ram #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/three_min_stacks_shared_store_unit.sv =====
// three_min_stacks_shared_store_unit: three min-tracking stacks in one shared entry ram
// depends on tmss_pkg, tmss_req_if, tmss_rsp_if and tmss_ram
//
//   channel  dir  handshake                      payload
//   in_req   in   in_req.valid / in_req.ready    req_type, stack_sel, push_value
//   out_rsp  out  out_rsp.valid / out_rsp.ready  status, top_value, top_minimum, fill_count
//
// each request runs through S_IDLE and S_RUN: the accept cycle issues the read of the stack's top
// entry, and in S_RUN the registered read data is at hand for the modify and write-back
// a new request is taken while an earlier result still waits in the output register;
// its S_RUN step holds until that result beat has gone
// reset (synchronous, rst_n low) clears the three fill counts and the handshake state;
// the entry ram has no reset and no clearing pass, entries are read only below the count

module three_min_stacks_shared_store_unit import tmss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tmss_req_if.sink    in_req,
  tmss_rsp_if.source  out_rsp
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state_r;

  // per-stack fill counts
  logic [CNT_W-1:0] cnt_r [NUM_STACKS];

  // request captured at accept
  req_kind_t                kind_r;
  logic                     bad_r;
  logic [SEL_W-1:0]         sel_r;
  logic signed [DATA_W-1:0] push_val_r;
  logic [CNT_W-1:0]         cnt_cur_r;
  logic [ADDR_W-1:0]        top_addr_r;

  // output register
  logic                     out_valid_r;
  status_t                  status_r;
  logic signed [DATA_W-1:0] top_value_r;
  logic signed [DATA_W-1:0] top_min_r;
  logic [FILL_W-1:0]        fill_r;

  // accept side address generation
  logic              accept;
  logic              in_bad;
  logic [CNT_W-1:0]  in_cnt;
  logic [ADDR_W-1:0] in_base;
  logic [ADDR_W-1:0] in_top_addr;

  // ram ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  entry_t            mem_rdata;

  // run-state results
  logic                     go;
  logic [CNT_W-1:0]         cnt_nxt;
  status_t                  status_nxt;
  logic signed [DATA_W-1:0] top_value_nxt;
  logic signed [DATA_W-1:0] top_min_nxt;
  logic signed [DATA_W-1:0] new_min;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  assign in_bad      = (in_req.stack_sel >= SEL_W'(NUM_STACKS));
  assign in_cnt      = in_bad ? '0 : cnt_r[in_req.stack_sel];
  // stack s owns entries s*STACK_DEPTH upward, top entry sits at base + count - 1
  assign in_base     = ADDR_W'(in_req.stack_sel) * ADDR_W'(STACK_DEPTH);
  assign in_top_addr = in_base + ADDR_W'(in_cnt) - ADDR_W'(1);

  // only read when there is a top entry to read
  assign mem_re = accept && !in_bad && (in_cnt != '0);

  tmss_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (in_top_addr),
    .rdata (mem_rdata)
  );

  // the run state may finish once the output register is free or being drained
  assign go = (state_r == S_RUN) && (!out_valid_r || out_rsp.ready);

  // running minimum for a push: the value itself on an empty stack
  always_comb begin
    new_min = push_val_r;
    if (cnt_cur_r != '0 && mem_rdata.minimum < push_val_r) begin
      new_min = mem_rdata.minimum;
    end
  end

  always_comb begin
    cnt_nxt       = cnt_cur_r;
    status_nxt    = ST_OK;
    top_value_nxt = '0;
    top_min_nxt   = '0;
    mem_we        = 1'b0;
    if (bad_r) begin
      status_nxt = ST_BADSTACK;
      cnt_nxt    = '0;
    end else begin
      case (kind_r)
        REQ_PUSH: begin
          if (cnt_cur_r >= CNT_W'(STACK_DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            mem_we  = go;
            cnt_nxt = cnt_cur_r + CNT_W'(1);
          end
        end
        REQ_POP, REQ_PEEK: begin
          if (cnt_cur_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            top_value_nxt = mem_rdata.value;
            top_min_nxt   = mem_rdata.minimum;
            if (kind_r == REQ_POP) begin
              cnt_nxt = cnt_cur_r - CNT_W'(1);
            end
          end
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end
  end

  // push lands one above the current top
  assign mem_waddr         = top_addr_r + ADDR_W'(1);
  assign mem_wdata.value   = push_val_r;
  assign mem_wdata.minimum = new_min;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      // drained beat not replaced by a new result
      if (out_valid_r && out_rsp.ready && !go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r     <= req_kind_t'(in_req.req_type);
            bad_r      <= in_bad;
            sel_r      <= in_req.stack_sel;
            push_val_r <= in_req.push_value;
            cnt_cur_r  <= in_cnt;
            top_addr_r <= in_top_addr;
            state_r    <= S_RUN;
          end
        end
        S_RUN: begin
          if (go) begin
            if (!bad_r) begin
              cnt_r[sel_r] <= cnt_nxt;
            end
            out_valid_r <= 1'b1;
            status_r    <= status_nxt;
            top_value_r <= top_value_nxt;
            top_min_r   <= top_min_nxt;
            fill_r      <= FILL_W'(cnt_nxt);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.top_value   = top_value_r;
  assign out_rsp.top_minimum = top_min_r;
  assign out_rsp.fill_count  = fill_r;

  // one request in flight: an accept is never followed directly by another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_req.ready)
    else $error("request accepted while previous one still in progress");

  // counts never pass the stack capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CNT_W'(STACK_DEPTH)) && (cnt_r[1] <= CNT_W'(STACK_DEPTH)) &&
    (cnt_r[2] <= CNT_W'(STACK_DEPTH)))
    else $error("stack fill count beyond capacity");

  // a write only happens for a valid push below capacity, and grows that count
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (!bad_r && cnt_cur_r < CNT_W'(STACK_DEPTH)) ##1
               (cnt_r[$past(sel_r)] == $past(cnt_cur_r) + CNT_W'(1)))
    else $error("entry write outside a legal push");

  // a full report always carries the capacity as fill count
  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (fill_r == FILL_W'(STACK_DEPTH)))
    else $error("full status with wrong fill count");

endmodule

// ===== sim/tmss_check_pkg.sv =====
// tmss_check_pkg: mirror of the three min-tracking stacks with a result checker
// depends on tmss_pkg for sizes, request kinds and status codes

package tmss_check_pkg;
  import tmss_pkg::*;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] top_minimum;
    logic [FILL_W-1:0]        fill_count;
  } stack_result_t;

  class min_stack_mirror;
    entry_t        entries[STORE_DEPTH];
    int unsigned   depth_of[NUM_STACKS];
    stack_result_t awaited_results[$];
    int            mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      foreach (depth_of[i]) depth_of[i] = 0;
      mismatches = 0;
    endfunction

    // apply one accepted request beat and queue the result it must give
    function void note_request(req_kind_t kind, logic [SEL_W-1:0] sel,
                               logic signed [DATA_W-1:0] value);
      stack_result_t            res;
      int unsigned              base;
      int unsigned              cnt;
      logic signed [DATA_W-1:0] run_min;
      res.status      = ST_OK;
      res.top_value   = '0;
      res.top_minimum = '0;
      res.fill_count  = '0;
      if (sel >= NUM_STACKS) begin
        res.status = ST_BADSTACK;
      end else begin
        base = sel * STACK_DEPTH;
        cnt  = depth_of[sel];
        case (kind)
          REQ_PUSH: begin
            if (cnt >= STACK_DEPTH) begin
              res.status = ST_FULL;
            end else begin
              run_min = value;
              if (cnt > 0) begin
                if ($signed(entries[base+cnt-1].minimum) < $signed(value))
                  run_min = entries[base+cnt-1].minimum;
              end
              entries[base+cnt].value   = value;
              entries[base+cnt].minimum = run_min;
              cnt++;
            end
          end
          REQ_POP, REQ_PEEK: begin
            if (cnt == 0) begin
              res.status = ST_EMPTY;
            end else begin
              res.top_value   = entries[base+cnt-1].value;
              res.top_minimum = entries[base+cnt-1].minimum;
              if (kind == REQ_POP) cnt--;
            end
          end
          default: cnt = 0;
        endcase
        depth_of[sel]  = cnt;
        res.fill_count = cnt[FILL_W-1:0];
      end
      awaited_results.push_back(res);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] top_value,
                               logic signed [DATA_W-1:0] top_minimum,
                               logic [FILL_W-1:0] fill_count);
      stack_result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status=%0d value=%0d min=%0d fill=%0d",
                   status, top_value, top_minimum, fill_count);
        return;
      end
      want = awaited_results.pop_front();
      if (status !== want.status || top_value !== want.top_value ||
          top_minimum !== want.top_minimum || fill_count !== want.fill_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status=%0d value=%0d min=%0d fill=%0d, got status=%0d value=%0d min=%0d fill=%0d",
                   want.status, want.top_value, want.top_minimum, want.fill_count,
                   status, top_value, top_minimum, fill_count);
      end
    endfunction
  endclass

endpackage

// ===== sim/three_min_stacks_shared_store_unit_tb.sv =====
// three_min_stacks_shared_store_unit_tb: random and directed requests into the stack unit,
// each result beat checked against a mirror of the stacks
// depends on tmss_pkg, tmss_req_if, tmss_rsp_if, tmss_check_pkg and the unit itself

module three_min_stacks_shared_store_unit_tb import tmss_pkg::*, tmss_check_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int               CLK_HALF     = 10;
  localparam int               RESET_CYCLES = 11;
  localparam int               RANDOM_ITEMS = 1725;
  localparam int               HOLD_START   = 300;   // requests sent before the long hold-off
  localparam int               HOLD_CYCLES  = 60;
  localparam int               STEADY_FROM  = 700;   // random items without any idling
  localparam int               STEADY_TO    = 1000;
  localparam int               QUIET_LIMIT  = 1000;  // cycles without any beat before giving up
  localparam int               TAIL_CYCLES  = 8;
  localparam logic [SEL_W-1:0] BAD_STACK    = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tmss_req_if in_req ();
  tmss_rsp_if out_rsp ();

  three_min_stacks_shared_store_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  min_stack_mirror mirror = new();

  int requests_sent = 0;
  int quiet_cycles  = 0;
  bit steady        = 1'b0;  // both sides keep going with no idling
  bit held_off      = 1'b0;

  always #CLK_HALF clk = ~clk;

  // mostly full-range values, with extremes and a narrow band so that minima tie
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -32'sd1;
        endcase
      end
      1, 2, 3: v = $signed($urandom_range(0, 200)) - 32'sd100;
      default: v = $signed($urandom());
    endcase
    return v;
  endfunction

  // offer one request beat from a falling edge and hold it until accepted;
  // returns at the falling edge after the accepting rising edge
  task automatic send_request(input req_kind_t kind, input logic [SEL_W-1:0] sel,
                              input logic signed [DATA_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.req_type   <= kind;
    in_req.stack_sel  <= sel;
    in_req.push_value <= value;
    do @(posedge clk); while (!in_req.ready);
    mirror.note_request(kind, sel, value);
    requests_sent++;
    @(negedge clk);
  endtask

  // directed opening: empty stacks, bad stack number on every kind, one stack filled
  // to the brim with extreme values, then the full push, peek, pop and clear
  task automatic run_directed();
    send_request(REQ_POP, 2'd0, 32'sd1234);
    send_request(REQ_PEEK, 2'd1, '0);
    send_request(REQ_PUSH, BAD_STACK, -32'sd1);
    send_request(REQ_POP, BAD_STACK, -32'sd1);
    send_request(REQ_PEEK, BAD_STACK, 32'sh7FFF_FFFF);
    send_request(REQ_CLEAR, BAD_STACK, 32'sh8000_0000);
    send_request(REQ_CLEAR, 2'd2, '0);
    send_request(REQ_PUSH, 2'd2, 32'sd5);
    send_request(REQ_PUSH, 2'd2, 32'sh7FFF_FFFF);   // larger value keeps the minimum
    send_request(REQ_PUSH, 2'd2, 32'sh8000_0000);   // most negative takes over
    send_request(REQ_PUSH, 2'd2, -32'sd1);
    send_request(REQ_PUSH, 2'd2, '0);
    for (int i = 5; i < STACK_DEPTH; i++) send_request(REQ_PUSH, 2'd2, pick_value());
    send_request(REQ_PUSH, 2'd2, -32'sd7);          // stack already full
    send_request(REQ_PEEK, 2'd2, '0);
    send_request(REQ_POP, 2'd2, '0);
    send_request(REQ_CLEAR, 2'd2, '0);
  endtask

  // random part: the push share drifts every few dozen requests so that stacks
  // swing between empty and full; clears and bad stack numbers stay rare
  task automatic run_random();
    int                 push_share;
    int                 roll;
    req_kind_t          kind;
    logic [SEL_W-1:0]   sel;
    push_share = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= STEADY_FROM && n < STEADY_TO);
      if (n % 60 == 0) push_share = $urandom_range(15, 85);
      sel  = SEL_W'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      if (roll < 3) sel = BAD_STACK;
      roll = $urandom_range(0, 99);
      if (roll < 4)
        kind = REQ_CLEAR;
      else if ($urandom_range(0, 99) < push_share)
        kind = REQ_PUSH;
      else
        kind = ($urandom_range(0, 2) == 0) ? REQ_PEEK : REQ_POP;
      send_request(kind, sel, pick_value());
    end
    steady = 1'b0;
  endtask

  // sender and end of run
  initial begin
    in_req.valid      = 1'b0;
    in_req.req_type   = REQ_PUSH;
    in_req.stack_sel  = '0;
    in_req.push_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random();
    in_req.valid <= 1'b0;
    while (mirror.awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // receiver: random stalls, none during the steady stretch, and one long hold-off
  // while the sender keeps offering so that the unit backs up into its input
  initial begin
    out_rsp.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held_off && requests_sent >= HOLD_START) begin
        held_off = 1'b1;
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_rsp.ready <= steady || ($urandom_range(0, 99) >= 20);
        @(negedge clk);
      end
    end
  end

  // result beats are checked at the rising edge; the watchdog counts cycles with no beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_rsp.valid && out_rsp.ready)
        mirror.check_result(out_rsp.status, out_rsp.top_value, out_rsp.top_minimum,
                            out_rsp.fill_count);
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

endmodule
